// ----- rtl/ple_pkg.sv -----
// Shared types and codes for the positional list engine.
// Holds command codes, status codes, field widths and the controller/datapath structs.
// No dependencies.
package ple_pkg;

  // Widths fixed by the item format
  localparam int unsigned ValueW   = 32;
  localparam int unsigned KindW    = 3;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned OutDataW = 40;

  // Command codes carried on the input tuser
  typedef enum logic [KindW-1:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_END   = 3'd1,
    KIND_INS_POS   = 3'd2,
    KIND_DEL_FRONT = 3'd3,
    KIND_DEL_END   = 3'd4,
    KIND_DEL_POS   = 3'd5,
    KIND_LIST      = 3'd6
  } kind_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Element store read address select
  typedef enum logic [1:0] {
    RD_PTR  = 2'd0,
    RD_PREV = 2'd1,
    RD_NEXT = 2'd2
  } rd_sel_e;

  // Result source select
  typedef enum logic [1:0] {
    EMIT_ERR  = 2'd0,
    EMIT_OK   = 2'd1,
    EMIT_TAKE = 2'd2,
    EMIT_LIST = 2'd3
  } emit_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic      accept;
    logic      setup;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      wr_shift;
    logic      wr_new;
    logic      ptr_inc;
    logic      ptr_dec;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      cap_removed;
    logic      emit;
    emit_sel_e emit_sel;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             chk_ok;
    logic             sh_more;
    logic             dl_more;
    logic             ls_last;
    logic             out_free;
  } sts_t;

endpackage

// ----- rtl/ple_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ple_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ple_ctrl.sv -----
// Controller state machine for the positional list engine.
// Sequences checks, shift loops, listing and result transfers; depends on ple_pkg.
module ple_ctrl
  import ple_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_CHECK  = 12'b0000_0000_0010,
    S_SH_RD  = 12'b0000_0000_0100,
    S_SH_WR  = 12'b0000_0000_1000,
    S_PUT    = 12'b0000_0001_0000,
    S_TK_RD  = 12'b0000_0010_0000,
    S_TK_CAP = 12'b0000_0100_0000,
    S_DL_RD  = 12'b0000_1000_0000,
    S_DL_WR  = 12'b0001_0000_0000,
    S_TK_OUT = 12'b0010_0000_0000,
    S_LS_RD  = 12'b0100_0000_0000,
    S_LS_OUT = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts_i.chk_ok) begin
          // Refused command: one error result
          if (sts_i.out_free) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_sel = EMIT_ERR;
            state_d        = S_IDLE;
          end
        end else begin
          cmd_o.setup = 1'b1;
          case (sts_i.kind)
            KIND_INS_FRONT, KIND_INS_END, KIND_INS_POS: state_d = S_SH_RD;
            KIND_DEL_FRONT, KIND_DEL_END, KIND_DEL_POS: state_d = S_TK_RD;
            KIND_LIST:                                  state_d = S_LS_RD;
            default:                                    state_d = S_IDLE;
          endcase
        end
      end
      S_SH_RD: begin
        // Open a gap: move elements up one slot from the tail down
        if (sts_i.sh_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_PREV;
          state_d      = S_SH_WR;
        end else begin
          state_d = S_PUT;
        end
      end
      S_SH_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.ptr_dec  = 1'b1;
        state_d        = S_SH_RD;
      end
      S_PUT: begin
        if (sts_i.out_free) begin
          cmd_o.wr_new   = 1'b1;
          cmd_o.cnt_inc  = 1'b1;
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_OK;
          state_d        = S_IDLE;
        end
      end
      S_TK_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_PTR;
        state_d      = S_TK_CAP;
      end
      S_TK_CAP: begin
        cmd_o.cap_removed = 1'b1;
        state_d           = S_DL_RD;
      end
      S_DL_RD: begin
        // Close the gap: move elements down one slot, from the target toward the tail
        if (sts_i.dl_more) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_NEXT;
          state_d      = S_DL_WR;
        end else begin
          state_d = S_TK_OUT;
        end
      end
      S_DL_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.ptr_inc  = 1'b1;
        state_d        = S_DL_RD;
      end
      S_TK_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.cnt_dec  = 1'b1;
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_TAKE;
          state_d        = S_IDLE;
        end
      end
      S_LS_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_PTR;
        state_d      = S_LS_OUT;
      end
      S_LS_OUT: begin
        // Read data holds until the result slot frees
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_sel = EMIT_LIST;
          if (sts_i.ls_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.ptr_inc = 1'b1;
            state_d       = S_LS_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/ple_dp.sv -----
// Datapath for the positional list engine: command registers, element count,
// walk pointer, element store and result register; depends on ple_pkg and ple_ram.
module ple_dp
  import ple_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned PosW  = $clog2(DEPTH + 2)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [KindW-1:0]    in_kind_i,
  input  logic [ValueW-1:0]   in_value_i,
  input  logic [PosW-1:0]     in_pos_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusW-1:0]  out_status_o,
  output logic [ValueW-1:0]   out_item_o,
  output logic                out_last_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned IdxW = $clog2(DEPTH);

  logic [KindW-1:0]   kind_q;
  logic [ValueW-1:0]  value_q;
  logic [PosW-1:0]    pos_q;
  logic [CntW-1:0]    count_q, count_d;
  logic [IdxW-1:0]    ptr_q, ptr_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [ValueW-1:0]  removed_q;
  logic               out_valid_q, out_valid_d;
  logic [StatusW-1:0] out_status_q, out_status_d;
  logic [ValueW-1:0]  out_item_q, out_item_d;
  logic               out_last_q, out_last_d;

  status_e            chk_status;
  logic               full, empty, pos_bad_ins, pos_bad_del;
  logic [PosW-1:0]    cnt_pos;
  logic [CntW-1:0]    ptr_cnt;
  logic [IdxW-1:0]    raddr;
  logic [IdxW-1:0]    waddr;
  logic [ValueW-1:0]  wdata;
  logic [ValueW-1:0]  rdata;
  logic               ls_last;
  logic               out_free;

  // Latch the command on transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q  <= in_kind_i;
      value_q <= in_value_i;
      pos_q   <= in_pos_i;
    end
  end

  // Command checks
  assign full        = (count_q == CntW'(DEPTH));
  assign empty       = (count_q == '0);
  assign cnt_pos     = PosW'(count_q);
  assign pos_bad_ins = (pos_q == '0) || (pos_q > cnt_pos + PosW'(1));
  assign pos_bad_del = (pos_q == '0) || (pos_q > cnt_pos);

  always_comb begin
    chk_status = ST_OK;
    idx_d      = '0;
    case (kind_q)
      KIND_INS_FRONT: begin
        chk_status = full ? ST_FULL : ST_OK;
        idx_d      = '0;
      end
      KIND_INS_END: begin
        chk_status = full ? ST_FULL : ST_OK;
        idx_d      = IdxW'(count_q);
      end
      KIND_INS_POS: begin
        if (empty) begin
          chk_status = ST_EMPTY;
        end else if (full) begin
          chk_status = ST_FULL;
        end else if (pos_bad_ins) begin
          chk_status = ST_RANGE;
        end
        idx_d = IdxW'(pos_q - PosW'(1));
      end
      KIND_DEL_FRONT: begin
        chk_status = empty ? ST_EMPTY : ST_OK;
        idx_d      = '0;
      end
      KIND_DEL_END: begin
        chk_status = empty ? ST_EMPTY : ST_OK;
        idx_d      = IdxW'(count_q - CntW'(1));
      end
      KIND_DEL_POS: begin
        if (empty) begin
          chk_status = ST_EMPTY;
        end else if (pos_bad_del) begin
          chk_status = ST_RANGE;
        end
        idx_d = IdxW'(pos_q - PosW'(1));
      end
      KIND_LIST: begin
        chk_status = empty ? ST_EMPTY : ST_OK;
      end
      default: begin
        chk_status = ST_OK;
      end
    endcase
  end

  // Walk pointer: inserts start at the tail, deletes at the target, listing at the front
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.setup) begin
      case (kind_q)
        KIND_INS_FRONT, KIND_INS_END, KIND_INS_POS: ptr_d = IdxW'(count_q);
        KIND_LIST:                                  ptr_d = '0;
        default:                                    ptr_d = idx_d;
      endcase
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + IdxW'(1);
    end else if (cmd_i.ptr_dec) begin
      ptr_d = ptr_q - IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    if (cmd_i.setup) begin
      idx_q <= idx_d;
    end
    if (cmd_i.cap_removed) begin
      removed_q <= rdata;
    end
  end

  // Element count
  always_comb begin
    count_d = count_q;
    if (cmd_i.cnt_inc) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Element store
  always_comb begin
    case (cmd_i.rd_sel)
      RD_PTR:  raddr = ptr_q;
      RD_PREV: raddr = ptr_q - IdxW'(1);
      RD_NEXT: raddr = ptr_q + IdxW'(1);
      default: raddr = ptr_q;
    endcase
  end

  assign waddr = cmd_i.wr_new ? idx_q : ptr_q;
  assign wdata = cmd_i.wr_new ? value_q : rdata;

  ple_ram #(
    .WIDTH (ValueW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_shift | cmd_i.wr_new),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Result register
  assign ptr_cnt  = CntW'(ptr_q);
  assign ls_last  = (ptr_cnt + CntW'(1) == count_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_item_d   = out_item_q;
    out_last_d   = out_last_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_last_d  = 1'b1;
      case (cmd_i.emit_sel)
        EMIT_ERR: begin
          out_status_d = chk_status;
          out_item_d   = '0;
        end
        EMIT_OK: begin
          out_status_d = ST_OK;
          out_item_d   = '0;
        end
        EMIT_TAKE: begin
          out_status_d = ST_OK;
          out_item_d   = removed_q;
        end
        EMIT_LIST: begin
          out_status_d = ST_OK;
          out_item_d   = rdata;
          out_last_d   = ls_last;
        end
        default: begin
          out_status_d = ST_OK;
          out_item_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_item_q   <= out_item_d;
    out_last_q   <= out_last_d;
  end

  // Status to controller
  assign sts_o.kind     = kind_q;
  assign sts_o.chk_ok   = (chk_status == ST_OK);
  assign sts_o.sh_more  = (ptr_q > idx_q);
  assign sts_o.dl_more  = (ptr_cnt + CntW'(1) < count_q);
  assign sts_o.ls_last  = ls_last;
  assign sts_o.out_free = out_free;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_item_o   = out_item_q;
  assign out_last_o   = out_last_q;

endmodule

// ----- rtl/positional_list_engine_unit.sv -----
// Top level of the positional list engine: stream ports, controller and datapath.
// Depends on ple_pkg, ple_ctrl, ple_dp (which holds the ple_ram element store).
//
//   Channel   Dir  Transfer when          Contents
//   s_axis    in   tvalid & tready        tdata: value, position; tuser: kind
//   m_axis    out  tvalid & tready        tdata: status, item; tlast: last
//
// One command is taken at a time; tready is high only while the engine is idle.
// A refused command gets its error result from the check. An insert moves m
// elements up one slot and a delete moves m elements down (m at most DEPTH-1),
// a listing reads out n elements; each moved element is a store read and a write.
// A held result stalls the engine only at its next result.
// Reset clears the element count and the result valid; the store needs no clearing.
module positional_list_engine_unit
  import ple_pkg::*;
#(
  parameter  int unsigned DEPTH   = 16,
  localparam int unsigned PosW    = $clog2(DEPTH + 2),
  localparam int unsigned InDataW = ((ValueW + PosW + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // value[31:0], position, zero pad
  input  logic [KindW-1:0]    s_axis_tuser_i,   // kind
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // status[1:0], item[33:2], zero pad
  output logic                m_axis_tlast_o
);

  cmd_t               cmd;
  sts_t               sts;
  logic [StatusW-1:0] out_status;
  logic [ValueW-1:0]  out_item;

  ple_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ple_dp #(
    .DEPTH (DEPTH),
    .PosW  (PosW)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_kind_i    (s_axis_tuser_i),
    .in_value_i   (s_axis_tdata_i[ValueW-1:0]),
    .in_pos_i     (s_axis_tdata_i[ValueW +: PosW]),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (out_status),
    .out_item_o   (out_item),
    .out_last_o   (m_axis_tlast_o)
  );

  // Pack the result payload
  assign m_axis_tdata_o = {(OutDataW - StatusW - ValueW)'(0), out_item, out_status};

endmodule
